// File: hdl/vmdp_pkg.sv
// Shared types, constants and constant tables for the VGA mode detector
// and converter programmer. No dependencies; every other file imports it.

package vmdp_pkg;

  // Input item: one measurement tick.
  typedef struct packed {
    logic [11:0] lines_per_frame;
    logic [15:0] line_period_count;
  } vmdp_in_t;

  // Result item: one register write.
  typedef struct packed {
    logic        target;
    logic [7:0]  reg_address;
    logic [11:0] reg_data;
    logic [7:0]  mode_index;
    logic        last;
  } vmdp_out_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LINE_TOL   = 8'd0;
  localparam logic [7:0] CFG_PERIOD_TOL = 8'd1;

  localparam logic [3:0] LINE_TOL_RST   = 4'd1;
  localparam logic [7:0] PERIOD_TOL_RST = 8'd10;

  // Write targets.
  localparam logic TGT_CONV = 1'b0;
  localparam logic TGT_CAPT = 1'b1;

  // Register addresses used by the mode writes.
  localparam logic [7:0] ADDR_PLL_HI  = 8'h01;
  localparam logic [7:0] ADDR_PLL_LO  = 8'h02;
  localparam logic [7:0] ADDR_VCO     = 8'h03;
  localparam logic [7:0] ADDR_ACT_W   = 8'h29;
  localparam logic [7:0] ADDR_ACT_H   = 8'h2a;
  localparam logic [7:0] ADDR_TOP     = 8'h2b;
  localparam logic [7:0] ADDR_LEFT    = 8'h2c;
  localparam logic [7:0] ADDR_CAPT_EN = 8'h2d;

  localparam logic [11:0] PLL_DEFAULT    = 12'd1688;
  localparam logic [11:0] DE_LEFT_ADJUST = 12'd7;
  localparam logic [7:0]  MODE_UNKNOWN   = 8'd255;

  localparam int TABLE_ROWS = 48;
  localparam int SETUP_LEN  = 49;
  localparam int MATCH_LEN  = 8;
  localparam int MISS_LEN   = 3;

  // Kind of write run in progress.
  typedef enum logic [1:0] {
    RUN_SETUP,
    RUN_MATCH,
    RUN_MISS
  } vmdp_run_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } vmdp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start_setup;
    logic step;
    logic commit;
    logic emit;
  } vmdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic setup_done;
    logic search_done;
    logic same_mode;
    logic out_free;
    logic last_write;
  } vmdp_sts_t;

  // One row of the mode table.
  typedef struct packed {
    logic [10:0] lines;
    logic [11:0] pix;
    logic [12:0] period;
    logic [10:0] act_w;
    logic [10:0] act_h;
    logic [8:0]  left;
    logic [5:0]  top;
    logic [7:0]  vco;
  } vmdp_row_t;

  function automatic vmdp_row_t mode_rom(input logic [5:0] idx);
    vmdp_row_t r;
    r = '0;
    case (idx)
      6'd0:  r = '{11'd525,  12'd800,  13'd3972, 11'd640,  11'd480,  9'd144, 6'd35, 8'h28};
      6'd1:  r = '{11'd520,  12'd832,  13'd3301, 11'd640,  11'd480,  9'd168, 6'd31, 8'h60};
      6'd2:  r = '{11'd500,  12'd840,  13'd3333, 11'd640,  11'd480,  9'd184, 6'd19, 8'h60};
      6'd3:  r = '{11'd509,  12'd832,  13'd2888, 11'd640,  11'd480,  9'd136, 6'd28, 8'h60};
      6'd4:  r = '{11'd625,  12'd1024, 13'd3555, 11'd800,  11'd600,  9'd206, 6'd25, 8'h60};
      6'd5:  r = '{11'd622,  12'd1024, 13'd3349, 11'd800,  11'd600,  9'd192, 6'd23, 8'h68};
      6'd6:  r = '{11'd628,  12'd1056, 13'd3299, 11'd800,  11'd600,  9'd222, 6'd28, 8'h68};
      6'd7:  r = '{11'd666,  12'd1040, 13'd2599, 11'd800,  11'd600,  9'd190, 6'd30, 8'h68};
      6'd8:  r = '{11'd625,  12'd1056, 13'd2666, 11'd800,  11'd600,  9'd245, 6'd25, 8'h68};
      6'd9:  r = '{11'd631,  12'd1048, 13'd2328, 11'd800,  11'd600,  9'd222, 6'd31, 8'h70};
      6'd10: r = '{11'd806,  12'd1344, 13'd2584, 11'd1024, 11'd768,  9'd301, 6'd36, 8'ha0};
      6'd11: r = '{11'd806,  12'd1328, 13'd2213, 11'd1024, 11'd768,  9'd280, 6'd35, 8'ha8};
      6'd12: r = '{11'd800,  12'd1312, 13'd2082, 11'd1024, 11'd768,  9'd277, 6'd32, 8'ha8};
      6'd13: r = '{11'd808,  12'd1376, 13'd1820, 11'd1024, 11'd768,  9'd309, 6'd40, 8'hb0};
      6'd14: r = '{11'd895,  12'd1520, 13'd2327, 11'd1152, 11'd864,  9'd309, 6'd31, 8'ha8};
      6'd15: r = '{11'd900,  12'd1600, 13'd1851, 11'd1152, 11'd864,  9'd389, 6'd36, 8'hb0};
      6'd16: r = '{11'd907,  12'd1552, 13'd1621, 11'd1152, 11'd864,  9'd332, 6'd43, 8'hb0};
      6'd17: r = '{11'd746,  12'd1664, 13'd2792, 11'd1280, 11'd720,  9'd315, 6'd24, 8'h98};
      6'd18: r = '{11'd750,  12'd1650, 13'd2777, 11'd1280, 11'd720,  9'd306, 6'd25, 8'h98};
      6'd19: r = '{11'd752,  12'd1696, 13'd2216, 11'd1280, 11'd720,  9'd344, 6'd31, 8'hb0};
      6'd20: r = '{11'd790,  12'd1440, 13'd2637, 11'd1280, 11'd768,  9'd112, 6'd19, 8'ha0};
      6'd21: r = '{11'd798,  12'd1664, 13'd2616, 11'd1280, 11'd768,  9'd325, 6'd28, 8'ha8};
      6'd22: r = '{11'd805,  12'd1696, 13'd2073, 11'd1280, 11'd768,  9'd338, 6'd35, 8'hb0};
      6'd23: r = '{11'd809,  12'd1712, 13'd1821, 11'd1280, 11'd768,  9'd345, 6'd39, 8'hb0};
      6'd24: r = '{11'd828,  12'd1680, 13'd2516, 11'd1280, 11'd800,  9'd339, 6'd28, 8'ha8};
      6'd25: r = '{11'd835,  12'd1712, 13'd1996, 11'd1280, 11'd800,  9'd354, 6'd35, 8'hb0};
      6'd26: r = '{11'd1000, 12'd1800, 13'd2083, 11'd1280, 11'd960,  9'd429, 6'd40, 8'hb0};
      6'd27: r = '{11'd1011, 12'd1728, 13'd1454, 11'd1280, 11'd960,  9'd388, 6'd51, 8'hf0};
      6'd28: r = '{11'd1066, 12'd1688, 13'd1953, 11'd1280, 11'd1024, 9'd365, 6'd42, 8'hb0};
      6'd29: r = '{11'd1066, 12'd1688, 13'd1562, 11'd1280, 11'd1024, 9'd396, 6'd41, 8'hf0};
      6'd30: r = '{11'd1072, 12'd1728, 13'd1371, 11'd1280, 11'd1024, 9'd388, 6'd48, 8'hf0};
      6'd31: r = '{11'd795,  12'd1792, 13'd2619, 11'd1360, 11'd768,  9'd372, 6'd25, 8'ha8};
      6'd32: r = '{11'd798,  12'd1792, 13'd2619, 11'd1366, 11'd768,  9'd364, 6'd24, 8'ha8};
      6'd33: r = '{11'd1099, 12'd1896, 13'd1519, 11'd1400, 11'd1050, 9'd248, 6'd46, 8'hf0};
      6'd34: r = '{11'd926,  12'd1600, 13'd2253, 11'd1440, 11'd900,  9'd112, 6'd23, 8'ha8};
      6'd35: r = '{11'd934,  12'd1904, 13'd2234, 11'd1440, 11'd900,  9'd388, 6'd32, 8'ha8};
      6'd36: r = '{11'd942,  12'd1936, 13'd1769, 11'd1440, 11'd900,  9'd400, 6'd39, 8'hf0};
      6'd37: r = '{11'd948,  12'd1952, 13'd1554, 11'd1440, 11'd900,  9'd256, 6'd45, 8'hf0};
      6'd38: r = '{11'd932,  12'd2128, 13'd2235, 11'd1600, 11'd900,  9'd264, 6'd31, 8'hb0};
      6'd39: r = '{11'd940,  12'd2160, 13'd1773, 11'd1600, 11'd900,  9'd460, 6'd41, 8'hf0};
      6'd40: r = '{11'd1250, 12'd2160, 13'd1666, 11'd1600, 11'd1200, 9'd498, 6'd50, 8'hf0};
      6'd41: r = '{11'd1080, 12'd1840, 13'd1932, 11'd1680, 11'd1050, 9'd116, 6'd27, 8'hb0};
      6'd42: r = '{11'd1089, 12'd2240, 13'd1914, 11'd1680, 11'd1050, 9'd460, 6'd36, 8'hf0};
      6'd43: r = '{11'd1125, 12'd2200, 13'd1853, 11'd1920, 11'd1080, 9'd196, 6'd41, 8'hf0};
      6'd44: r = '{11'd1235, 12'd2080, 13'd1688, 11'd1920, 11'd1200, 9'd112, 6'd32, 8'hf0};
      6'd45: r = '{11'd1125, 12'd2640, 13'd2222, 11'd1920, 11'd1080, 9'd246, 6'd32, 8'hf0};
      6'd46: r = '{11'd1125, 12'd2200, 13'd3704, 11'd1920, 11'd1080, 9'd240, 6'd41, 8'ha8};
      6'd47: r = '{11'd1125, 12'd2640, 13'd4438, 11'd1920, 11'd1080, 9'd240, 6'd41, 8'ha8};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Converter set-up run: address in the upper byte, data in the lower.
  function automatic logic [15:0] setup_rom(input logic [5:0] idx);
    logic [15:0] w;
    w = '0;
    case (idx)
      6'd0:  w = {8'h01, PLL_DEFAULT[11:4]};
      6'd1:  w = {8'h02, PLL_DEFAULT[3:0], 4'h0};
      6'd2:  w = 16'h03b0;
      6'd3:  w = 16'h0480;
      6'd4:  w = 16'h0550;
      6'd5:  w = 16'h0600;
      6'd6:  w = 16'h0750;
      6'd7:  w = 16'h0800;
      6'd8:  w = 16'h0950;
      6'd9:  w = 16'h0a00;
      6'd10: w = 16'h0b40;
      6'd11: w = 16'h0c00;
      6'd12: w = 16'h0d40;
      6'd13: w = 16'h0e00;
      6'd14: w = 16'h0f40;
      6'd15: w = 16'h1000;
      6'd16: w = 16'h1120;
      6'd17: w = 16'h1298;
      6'd18: w = 16'h1320;
      6'd19: w = 16'h1498;
      6'd20: w = 16'h1505;
      6'd21: w = 16'h1600;
      6'd22: w = 16'h1700;
      6'd23: w = 16'h1820;
      6'd24: w = 16'h1908;
      6'd25: w = 16'h1a28;
      6'd26: w = 16'h1b53;
      6'd27: w = 16'h1cff;
      6'd28: w = 16'h1d79;
      6'd29: w = 16'h1ea4;
      6'd30: w = 16'h1f92;
      6'd31: w = 16'h2045;
      6'd32: w = 16'h2120;
      6'd33: w = 16'h2232;
      6'd34: w = 16'h230a;
      6'd35: w = 16'h28bf;
      6'd36: w = 16'h2902;
      6'd37: w = 16'h2c00;
      6'd38: w = 16'h2de8;
      6'd39: w = 16'h2ee0;
      6'd40: w = 16'h3c00;
      6'd41: w = 16'h0b00;
      6'd42: w = 16'h0c80;
      6'd43: w = 16'h0d00;
      6'd44: w = 16'h0e80;
      6'd45: w = 16'h0f00;
      6'd46: w = 16'h1080;
      6'd47: w = 16'h1820;
      6'd48: w = 16'h1b7b;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/vmdp_ctrl.sv
// Controller state machine for the VGA mode detector and programmer.
// Depends on vmdp_pkg; drives the datapath through vmdp_cmd_t.

module vmdp_ctrl import vmdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vmdp_sts_t sts,
  output vmdp_cmd_t cmd
);

  vmdp_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.setup_done) begin
            state_nxt = ST_SEARCH;
          end else begin
            cmd.start_setup = 1'b1;
            state_nxt       = ST_WRITE;
          end
        end
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          if (sts.same_mode) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = ST_WRITE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_write) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/vmdp_datapath.sv
// Datapath for the VGA mode detector and programmer: measurement registers,
// mode table search, mode state, write generation and output register.
// Depends on vmdp_pkg for types, constants and the constant tables.

module vmdp_datapath import vmdp_pkg::*; #(
  parameter int NUM_MODES = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  vmdp_in_t   in_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  vmdp_cmd_t  cmd,
  output vmdp_sts_t  sts,
  output logic       out_valid,
  input  logic       out_ready,
  output vmdp_out_t  out_data
);

  localparam logic [7:0] MISS_IDX  = 8'(NUM_MODES);
  localparam logic [7:0] LAST_IDX  = 8'(NUM_MODES - 1);
  localparam logic [7:0] TBL_ROWS  = 8'(TABLE_ROWS);

  logic [3:0]  line_tol_r;
  logic [7:0]  period_tol_r;
  logic        setup_done_r;
  logic [7:0]  cur_mode_r;
  logic [11:0] lines_r;
  logic [16:0] period_r;
  logic [7:0]  idx_r;
  logic [5:0]  row_idx_r;
  logic [5:0]  wr_cnt_r;
  vmdp_run_t   run_r;
  logic        out_valid_r;
  vmdp_out_t   out_data_r;

  logic [18:0] period_x5;
  vmdp_row_t   srch_row;
  vmdp_row_t   emit_row;
  logic [12:0] lines_lo, lines_hi;
  logic [17:0] per_lo, per_hi;
  logic        hit;
  logic [7:0]  res_idx;
  logic [15:0] setup_word;
  vmdp_out_t   wr_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_tol_r   <= LINE_TOL_RST;
      period_tol_r <= PERIOD_TOL_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LINE_TOL) begin
        line_tol_r <= cfg_data[3:0];
      end else if (cfg_index == CFG_PERIOD_TOL) begin
        period_tol_r <= cfg_data;
      end
    end
  end

  // Rescale the line period count to ticks of a clock 5/4 as fast: p * 5 / 4.
  assign period_x5 = {3'b000, in_data.line_period_count}
                   + {1'b0, in_data.line_period_count, 2'b00};

  // Measurement capture and search index.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      lines_r  <= in_data.lines_per_frame;
      period_r <= period_x5[18:2];
      idx_r    <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 8'd1;
    end
  end

  // Tolerance window test against the table entry under the search index.
  // Both bounds are inclusive and are computed wide enough not to wrap.
  assign srch_row = mode_rom(idx_r[5:0]);
  assign lines_lo = {1'b0, lines_r} + {9'd0, line_tol_r};
  assign lines_hi = {2'b00, srch_row.lines} + {9'd0, line_tol_r};
  assign per_lo   = {1'b0, period_r} + {10'd0, period_tol_r};
  assign per_hi   = {5'd0, srch_row.period} + {10'd0, period_tol_r};

  assign hit = (idx_r < TBL_ROWS)
            && (lines_lo >= {2'b00, srch_row.lines})
            && ({1'b0, lines_r} <= lines_hi)
            && (per_lo >= {5'd0, srch_row.period})
            && ({1'b0, period_r} <= per_hi);

  assign res_idx = hit ? idx_r : MISS_IDX;

  // Mode state and the kind of write run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_done_r <= 1'b0;
      cur_mode_r   <= MISS_IDX;
      run_r        <= RUN_SETUP;
      wr_cnt_r     <= '0;
    end else begin
      if (cmd.start_setup) begin
        setup_done_r <= 1'b1;
        cur_mode_r   <= MISS_IDX;
        run_r        <= RUN_SETUP;
        wr_cnt_r     <= '0;
      end else if (cmd.commit) begin
        wr_cnt_r <= '0;
        if (hit) begin
          cur_mode_r <= idx_r;
          run_r      <= RUN_MATCH;
        end else begin
          cur_mode_r <= MODE_UNKNOWN;
          run_r      <= RUN_MISS;
        end
      end else if (cmd.emit) begin
        wr_cnt_r <= wr_cnt_r + 6'd1;
      end
    end
  end

  // Row whose clock and window settings are written; a miss uses row 0.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      row_idx_r <= hit ? idx_r[5:0] : 6'd0;
    end
  end

  assign emit_row   = mode_rom(row_idx_r);
  assign setup_word = setup_rom(wr_cnt_r);

  // Build the write for the current step of the run.
  always_comb begin
    wr_item            = '0;
    wr_item.mode_index = cur_mode_r;
    case (run_r)
      RUN_SETUP: begin
        wr_item.target      = TGT_CONV;
        wr_item.reg_address = setup_word[15:8];
        wr_item.reg_data    = {4'h0, setup_word[7:0]};
        wr_item.last        = (wr_cnt_r == 6'(SETUP_LEN - 1));
      end
      RUN_MATCH, RUN_MISS: begin
        if (run_r == RUN_MATCH) begin
          wr_item.last = (wr_cnt_r == 6'(MATCH_LEN - 1));
        end else begin
          wr_item.last = (wr_cnt_r == 6'(MISS_LEN - 1));
        end
        case (wr_cnt_r[2:0])
          3'd0: begin
            wr_item.target      = TGT_CONV;
            wr_item.reg_address = ADDR_VCO;
            wr_item.reg_data    = {4'h0, emit_row.vco};
          end
          3'd1: begin
            wr_item.target      = TGT_CONV;
            wr_item.reg_address = ADDR_PLL_HI;
            wr_item.reg_data    = {4'h0, emit_row.pix[11:4]};
          end
          3'd2: begin
            wr_item.target      = TGT_CONV;
            wr_item.reg_address = ADDR_PLL_LO;
            wr_item.reg_data    = {4'h0, emit_row.pix[3:0], 4'h0};
          end
          3'd3: begin
            wr_item.target      = TGT_CAPT;
            wr_item.reg_address = ADDR_ACT_W;
            wr_item.reg_data    = {1'b0, emit_row.act_w};
          end
          3'd4: begin
            wr_item.target      = TGT_CAPT;
            wr_item.reg_address = ADDR_ACT_H;
            wr_item.reg_data    = {1'b0, emit_row.act_h};
          end
          3'd5: begin
            wr_item.target      = TGT_CAPT;
            wr_item.reg_address = ADDR_TOP;
            wr_item.reg_data    = {6'd0, emit_row.top};
          end
          3'd6: begin
            wr_item.target      = TGT_CAPT;
            wr_item.reg_address = ADDR_LEFT;
            wr_item.reg_data    = {3'd0, emit_row.left} - DE_LEFT_ADJUST;
          end
          default: begin
            wr_item.target      = TGT_CAPT;
            wr_item.reg_address = ADDR_CAPT_EN;
            wr_item.reg_data    = 12'd1;
          end
        endcase
      end
      default: begin
        wr_item.last = 1'b1;
      end
    endcase
  end

  // Output register: a transfer frees it, a new write reloads it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= wr_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status for the controller.
  assign sts.setup_done  = setup_done_r;
  assign sts.search_done = hit || (idx_r == LAST_IDX);
  assign sts.same_mode   = (res_idx == cur_mode_r);
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.last_write  = wr_item.last;

endmodule

// File: hdl/vga_mode_detect_programmer.sv
// Top level of the VGA mode detector and converter programmer.
// Depends on vmdp_pkg, vmdp_ctrl and vmdp_datapath.
//
//  Channel | Dir | Ports                              | Payload
//  --------+-----+------------------------------------+----------------------------
//  input   | in  | in_valid, in_ready, in_data        | vmdp_in_t (lines, period)
//  result  | out | out_valid, out_ready, out_data     | vmdp_out_t (one reg write)
//  config  | in  | cfg_valid, cfg_ready, cfg_index,   | index 0 line tolerance,
//          |     | cfg_data                           | index 1 period tolerance
//
// The first item after reset produces 49 converter writes, one per cycle while
// the output is not stalled. Each later item is captured and then searched,
// one table entry per cycle (up to NUM_MODES entries), then gives 8 writes on
// a match, 3 on a miss, none if the search result equals the current mode.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds the write sequence; the next item is taken as soon
// as the final write of a run sits in the output register.

module vga_mode_detect_programmer import vmdp_pkg::*; #(
  parameter int NUM_MODES = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vmdp_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vmdp_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  vmdp_cmd_t cmd;
  vmdp_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencing of set-up, search and write runs.
  vmdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, table search and write generation.
  vmdp_datapath #(
    .NUM_MODES (NUM_MODES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
